>>> src/brr_adpcm_decoder_top_defines.svh
// Assertion macros shared by the decoder modules.
// Each macro expects clk and arst_n in scope.
`ifndef BRR_ADPCM_DECODER_TOP_DEFINES_SVH
`define BRR_ADPCM_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BRR_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("brr: forbidden condition seen");

`define BRR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brr: implication violated");

`else

`define BRR_ASSERT_NEVER(lbl, expr)

`define BRR_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

>>> src/brr_pkg.sv
package brr_pkg;

	// Block layout: one header then this many data bytes
	localparam logic [3:0] BLOCK_DATA_BYTES = 4'd8;
	localparam logic [3:0] POS_HEADER       = 4'd0;

	// Shift ranges above this collapse to SCALE_FLOOR for a negative nibble, else zero
	localparam logic [3:0] SHIFT_MAX = 4'd12;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Arithmetic width for scaled nibble plus predictor
	localparam int ACC_W = 20;
	localparam logic signed [ACC_W-1:0] SCALE_FLOOR = -20'sd2048;
	localparam logic signed [ACC_W-1:0] CLAMP_MAX   = 20'sd32767;
	localparam logic signed [ACC_W-1:0] CLAMP_MIN   = -20'sd32768;

	// Filter codes
	typedef enum logic [1:0] {
		FILT_NONE = 2'd0,
		FILT_ONE  = 2'd1,
		FILT_TWO  = 2'd2,
		FILT_TRI  = 2'd3
	} brr_filter_t;

	// One data byte with the block context needed to decode it
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [3:0]  shift_range;
		brr_filter_t filter_sel;
		logic        clr_hist;   // zero history before the first nibble
		logic        blk_last;
		logic        end_flag;
	} brr_entry_t;

endpackage

>>> src/brr_front.sv
module brr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tuser,
	output logic                push,
	output brr_pkg::brr_entry_t push_entry,
	input  logic                full
);
	import brr_pkg::*;

	logic [3:0]  pos_q;
	logic [3:0]  shift_q;
	brr_filter_t filt_q;
	logic        end_q;
	logic        stopped_q;
	logic        clr_pend_q;

	logic        accept;
	logic [3:0]  eff_pos;
	logic        eff_stop;
	logic        eff_clr;
	logic        is_header;
	logic        is_data;
	logic        blk_last;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// restart takes effect before the byte is classified
	assign eff_pos   = s_tuser ? POS_HEADER : pos_q;
	assign eff_stop  = s_tuser ? 1'b0 : stopped_q;
	assign eff_clr   = s_tuser || clr_pend_q;
	assign is_header = !eff_stop && (eff_pos == POS_HEADER);
	assign is_data   = !eff_stop && (eff_pos != POS_HEADER);
	assign blk_last  = (eff_pos >= BLOCK_DATA_BYTES);

	assign push = accept && is_data;

	always_comb begin
		push_entry.data_byte   = s_tdata;
		push_entry.shift_range = shift_q;
		push_entry.filter_sel  = filt_q;
		push_entry.clr_hist    = eff_clr;
		push_entry.blk_last    = blk_last;
		push_entry.end_flag    = end_q;
	end

	// block position and header state; a stopped stream without restart keeps its state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_HEADER;
			shift_q    <= 4'd0;
			filt_q     <= FILT_NONE;
			end_q      <= 1'b0;
			stopped_q  <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			if (is_header) begin
				shift_q    <= s_tdata[7:4];
				filt_q     <= brr_filter_t'(s_tdata[3:2]);
				end_q      <= s_tdata[0];
				pos_q      <= 4'd1;
				stopped_q  <= 1'b0;
				clr_pend_q <= eff_clr;
			end else if (is_data) begin
				clr_pend_q <= 1'b0;
				if (blk_last) begin
					pos_q     <= POS_HEADER;
					stopped_q <= end_q;
				end else begin
					pos_q     <= eff_pos + 4'd1;
					stopped_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> src/brr_queue.sv
module brr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  brr_pkg::brr_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                valid,
	output brr_pkg::brr_entry_t entry
);
	import brr_pkg::*;

	brr_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign entry = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/brr_back.sv
`include "brr_adpcm_decoder_top_defines.svh"

module brr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  brr_pkg::brr_entry_t q_entry,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic                m_tlast,
	output logic [1:0]          m_tuser
);
	import brr_pkg::*;

	logic               phase_q;     // 0 = high nibble, 1 = low nibble
	logic signed [14:0] p1_q;
	logic signed [14:0] p2_q;
	logic               out_valid_q;
	logic [14:0]        out_sample_q;
	logic               out_last_q;
	logic               out_blast_q;
	logic               out_end_q;

	logic                    advance;
	logic                    clr;
	logic [3:0]              nib;
	logic signed [ACC_W-1:0] nib_x;
	logic signed [ACC_W-1:0] scaled;
	logic signed [ACC_W-1:0] p1;
	logic signed [ACC_W-1:0] p2;
	logic signed [ACC_W-1:0] pred;
	logic signed [ACC_W-1:0] sum;
	logic [15:0]             clamped;

	assign advance = q_valid && (!out_valid_q || m_tready);
	assign q_pop   = advance && phase_q;

	// select nibble and history
	assign clr   = q_entry.clr_hist && !phase_q;
	assign nib   = phase_q ? q_entry.data_byte[3:0] : q_entry.data_byte[7:4];
	assign nib_x = {{(ACC_W-4){nib[3]}}, nib};
	assign p1    = clr ? '0 : ACC_W'(p1_q);
	assign p2    = clr ? '0 : ACC_W'(p2_q);

	// scaled nibble
	always_comb begin
		if (q_entry.shift_range <= SHIFT_MAX) begin
			scaled = (nib_x <<< q_entry.shift_range) >>> 1;
		end else begin
			scaled = nib[3] ? SCALE_FLOOR : '0;
		end
	end

	// predictor from the two previous samples
	always_comb begin
		case (q_entry.filter_sel)
			FILT_NONE: pred = '0;
			FILT_ONE:  pred = p1 + ((-p1) >>> 4);
			FILT_TWO:  pred = (p1 <<< 1) + ((-((p1 <<< 1) + p1)) >>> 5) - p2 + (p2 >>> 4);
			FILT_TRI:  pred = (p1 <<< 1) + ((-((p1 <<< 3) + (p1 <<< 2) + p1)) >>> 6)
					- p2 + (((p2 <<< 1) + p2) >>> 4);
			default:   pred = '0;
		endcase
	end

	// clamp to 16 bits, keep low 15
	always_comb begin
		sum = scaled + pred;
		if (sum < CLAMP_MIN) begin
			clamped = CLAMP_MIN[15:0];
		end else if (sum > CLAMP_MAX) begin
			clamped = CLAMP_MAX[15:0];
		end else begin
			clamped = sum[15:0];
		end
	end

	// nibble phase and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			p1_q    <= '0;
			p2_q    <= '0;
		end else if (advance) begin
			phase_q <= !phase_q;
			p2_q    <= p1[14:0];
			p1_q    <= clamped[14:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= clamped[14:0];
			out_last_q   <= phase_q;
			out_blast_q  <= phase_q && q_entry.blk_last;
			out_end_q    <= phase_q && q_entry.blk_last && q_entry.end_flag;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_sample_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_end_q, out_blast_q};

	`BRR_ASSERT_IMP(a_end_on_blk_last, out_valid_q && out_end_q, out_blast_q)
	`BRR_ASSERT_IMP(a_blk_last_on_last, out_valid_q && out_blast_q, out_last_q)
	`BRR_ASSERT_IMP(a_low_nibble_held, phase_q, q_valid)
	`BRR_ASSERT_IMP(a_pop_after_two, q_pop, phase_q && advance)

endmodule

>>> src/brr_adpcm_decoder_top.sv
// A data byte's first sample passes through the queue and the output register;
// its second sample follows when the output is not stalled.
// Data bytes are paced by the sample unit in the back end, which forms one sample
// per cycle from the previous two unless the output stalls; headers stay in the front end.
// Reset (arst_n low, asynchronous): block position, history, queue and output clear.
module brr_adpcm_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [14:0] sample, [15] zero
	output logic        m_tlast,
	output logic [1:0]  m_tuser    // [0] block_last, [1] stream_end
);
	import brr_pkg::*;

	logic       push;
	brr_entry_t push_entry;
	logic       full;
	logic       pop;
	logic       q_valid;
	brr_entry_t q_entry;

	brr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	brr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.valid      (q_valid),
		.entry      (q_entry)
	);

	brr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
